### hdl/bbc_pkg.sv
// Package for the buffer cache LRU manager: sizes, command and status codes
// and the result record type. No dependencies.
package bbc_pkg;
  localparam int SLOT_COUNT = 32;
  localparam int SW = 5;
  localparam int MAX_OUT = 32;

  localparam logic [2:0] CMD_ACQUIRE = 3'd0;
  localparam logic [2:0] CMD_RELEASE = 3'd1;
  localparam logic [2:0] CMD_PIN     = 3'd2;
  localparam logic [2:0] CMD_UNPIN   = 3'd3;
  localparam logic [2:0] CMD_DIRTY   = 3'd4;
  localparam logic [2:0] CMD_FLUSH   = 3'd5;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_BAD   = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_UNDER = 2'd3;

  // slot record: device, block (tags, memory); in_use, dirty, count in flops
  localparam int TAG_W = 40;

  typedef struct packed {
    logic [4:0]  result_slot;
    logic        was_hit;
    logic        fill_needed;
    logic        writeback_needed;
    logic [7:0]  writeback_device;
    logic [31:0] writeback_block;
    logic [1:0]  status;
    logic        last;
  } result_t;
endpackage

### hdl/block_buffer_cache_lru_manager.sv
// Top level of the buffer cache LRU manager: sequencer over tag and recency
// memories. Uses bbc_pkg and bbc_ram.
//
// channel | dir | handshake              | payload
// s_axis  | in  | s_axis_tvalid/tready   | tdata: command,device_id,block_number,slot_index
// m_axis  | out | m_axis_tvalid/tready   | tdata: result fields, tlast = last
//
// One item at a time. Acquire looks up each recency position through S_LOOK,
// S_LCHK and S_VIC, then searches for a victim from the back of the list
// through S_VCHK and S_OUT per position and retags in S_VTAG. Release to
// zero rewrites the list through S_MOVF and S_MOVS per position. Flush
// visits each position through S_FL, S_FCHK and S_FOUT and stops after the
// last dirty slot. Other commands give their result the cycle after the item.
// The next item waits for the result to be taken. Reset is synchronous: counts
// and flags clear at once, the recency list reads as its reset order until
// each entry is rewritten. A stalled result holds the sequencer and the input.
module block_buffer_cache_lru_manager (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // command[2:0], device_id[10:3], block_number[42:11], slot_index[47:43]
  input  logic [47:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // result_slot[4:0], was_hit[5], fill_needed[6], writeback_needed[7],
  // writeback_device[15:8], writeback_block[47:16], status[49:48]
  output logic [55:0] m_axis_tdata,
  output logic        m_axis_tlast
);
  localparam int N = bbc_pkg::SLOT_COUNT;
  localparam int SW = bbc_pkg::SW;
  localparam int PW = $clog2(N);

  localparam logic [3:0] S_IDLE = 4'd0, S_LOOK = 4'd1, S_LCHK = 4'd2,
                         S_VIC = 4'd3, S_VCHK = 4'd4, S_OUT = 4'd5,
                         S_MOVF = 4'd6, S_MOVS = 4'd7, S_FL = 4'd8,
                         S_FCHK = 4'd9, S_FOUT = 4'd10, S_VTAG = 4'd11;

  logic [3:0] state;
  logic [7:0] dev;
  logic [31:0] blk;
  logic [SW-1:0] sidx;
  logic [PW:0] pos;
  logic [SW-1:0] vslot, carry;

  logic [N-1:0] in_use, dirty;
  logic [7:0] cnt [N];

  logic rec_we;
  logic [PW-1:0] rec_wa, rec_ra;
  logic [SW-1:0] rec_wd, rec_rd;
  logic tag_we;
  logic [SW-1:0] tag_wa, tag_ra;
  logic [bbc_pkg::TAG_W-1:0] tag_wd, tag_rd;
  logic [N-1:0] rinit;
  logic [SW-1:0] rec_q;

  bbc_pkg::result_t res;
  logic ovalid;

  logic [2:0] in_cmd;
  logic [SW-1:0] in_slot;
  logic [31:0] in_blk;
  logic slot_ok, slot_cmd;
  logic [1:0] in_status;
  logic [N-1:0] slot_bit, dirty_left;

  bbc_ram #(.WIDTH(SW), .DEPTH(N)) u_rec (
    .clk(clk), .we(rec_we), .waddr(rec_wa), .wdata(rec_wd),
    .raddr(rec_ra), .rdata(rec_rd));
  bbc_ram #(.WIDTH(bbc_pkg::TAG_W), .DEPTH(N)) u_tag (
    .clk(clk), .we(tag_we), .waddr(tag_wa), .wdata(tag_wd),
    .raddr(tag_ra), .rdata(tag_rd));

  // recency entries not yet written read as their reset value
  logic [PW-1:0] rec_ra_q;
  always_ff @(posedge clk) rec_ra_q <= rec_ra;
  assign rec_q = rinit[rec_ra_q] ? rec_rd : SW'(N - 1 - int'(rec_ra_q));

  assign s_axis_tready = (state == S_IDLE) && !ovalid;
  assign m_axis_tvalid = ovalid;
  assign m_axis_tdata = {6'd0, res.status, res.writeback_block, res.writeback_device,
                         res.writeback_needed, res.fill_needed, res.was_hit,
                         res.result_slot};
  assign m_axis_tlast = res.last;

  assign in_cmd = s_axis_tdata[2:0];
  assign in_blk = s_axis_tdata[42:11];
  assign in_slot = s_axis_tdata[47:43];
  assign slot_ok = int'(in_slot) < N;
  assign slot_cmd = in_cmd == bbc_pkg::CMD_RELEASE || in_cmd == bbc_pkg::CMD_PIN ||
                    in_cmd == bbc_pkg::CMD_UNPIN || in_cmd == bbc_pkg::CMD_DIRTY;

  always_comb begin
    in_status = bbc_pkg::ST_OK;
    if (in_cmd == bbc_pkg::CMD_ACQUIRE && in_blk == 32'hFFFF_FFFF)
      in_status = bbc_pkg::ST_BAD;
    else if ((in_cmd == bbc_pkg::CMD_RELEASE || in_cmd == bbc_pkg::CMD_UNPIN) &&
             slot_ok && cnt[in_slot] == 8'd0)
      in_status = bbc_pkg::ST_UNDER;
  end

  // dirty slots still to report once the current one is cleaned
  assign slot_bit = {{(N-1){1'b0}}, 1'b1} << rec_q;
  assign dirty_left = in_use & dirty & ~slot_bit;

  always_comb begin
    rec_ra = pos[PW-1:0];
    tag_ra = rec_q;
    rec_we = 1'b0;
    rec_wa = pos[PW-1:0];
    rec_wd = carry;
    tag_we = 1'b0;
    tag_wa = vslot;
    tag_wd = {blk, dev};
    case (state)
      S_VTAG: tag_we = 1'b1;
      S_MOVS: begin
        rec_we = 1'b1;
        rec_wa = pos[PW-1:0];
      end
      default: ;
    endcase
  end

  logic go;
  assign go = s_axis_tvalid && s_axis_tready;
  logic tagmatch;
  assign tagmatch = in_use[rec_q] && tag_rd[7:0] == dev && tag_rd[39:8] == blk;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ovalid <= 1'b0;
      in_use <= '0;
      dirty <= '0;
      rinit <= '0;
      for (int i = 0; i < N; i++) cnt[i] <= 8'd0;
    end else begin
      if (ovalid && m_axis_tready) ovalid <= 1'b0;
      case (state)
        S_IDLE: if (go) begin
          dev <= s_axis_tdata[10:3];
          blk <= in_blk;
          sidx <= in_slot;
          pos <= '0;
          res.was_hit <= 1'b0;
          res.fill_needed <= 1'b0;
          res.writeback_needed <= 1'b0;
          res.writeback_device <= '0;
          res.writeback_block <= '0;
          res.last <= 1'b1;
          res.result_slot <= slot_cmd ? in_slot : '0;
          res.status <= in_status;
          case (in_cmd)
            bbc_pkg::CMD_ACQUIRE: begin
              if (in_status == bbc_pkg::ST_BAD) ovalid <= 1'b1;
              else state <= S_LOOK;
            end
            bbc_pkg::CMD_FLUSH: begin
              if ((in_use & dirty) == '0) ovalid <= 1'b1;
              else state <= S_FL;
            end
            bbc_pkg::CMD_RELEASE, bbc_pkg::CMD_UNPIN: begin
              if (slot_ok && cnt[in_slot] != 8'd0)
                cnt[in_slot] <= cnt[in_slot] - 8'd1;
              if (slot_ok && in_cmd == bbc_pkg::CMD_RELEASE && cnt[in_slot] == 8'd1) begin
                carry <= in_slot;
                state <= S_MOVF;
              end else ovalid <= 1'b1;
            end
            bbc_pkg::CMD_PIN: begin
              if (slot_ok && cnt[in_slot] != 8'hFF)
                cnt[in_slot] <= cnt[in_slot] + 8'd1;
              ovalid <= 1'b1;
            end
            bbc_pkg::CMD_DIRTY: begin
              if (slot_ok && in_use[in_slot])
                dirty[in_slot] <= 1'b1;
              ovalid <= 1'b1;
            end
            default: ovalid <= 1'b1;
          endcase
        end
        S_LOOK: state <= S_LCHK; // recency read in flight
        S_LCHK: state <= S_VIC;  // tag read in flight
        S_VIC: begin
          if (tagmatch) begin
            if (cnt[rec_q] != 8'hFF) cnt[rec_q] <= cnt[rec_q] + 8'd1;
            res.result_slot <= rec_q;
            res.was_hit <= 1'b1;
            ovalid <= 1'b1;
            state <= S_IDLE;
          end else if (pos == (PW+1)'(N - 1)) begin
            pos <= (PW+1)'(N - 1);
            state <= S_VCHK;
          end else begin
            pos <= pos + (PW+1)'(1);
            state <= S_LOOK;
          end
        end
        S_VCHK: state <= S_OUT;
        S_OUT: begin
          if (cnt[rec_q] == 8'd0) begin
            vslot <= rec_q;
            res.result_slot <= rec_q;
            res.fill_needed <= 1'b1;
            state <= S_VTAG;
          end else if (pos == '0) begin
            res.status <= bbc_pkg::ST_FULL;
            ovalid <= 1'b1;
            state <= S_IDLE;
          end else begin
            pos <= pos - (PW+1)'(1);
            state <= S_VCHK;
          end
        end
        S_VTAG: begin
          if (in_use[vslot] && dirty[vslot]) begin
            res.writeback_needed <= 1'b1;
            res.writeback_device <= tag_rd[7:0];
            res.writeback_block <= tag_rd[39:8];
          end
          in_use[vslot] <= 1'b1;
          dirty[vslot] <= 1'b0;
          cnt[vslot] <= 8'd1;
          ovalid <= 1'b1;
          state <= S_IDLE;
        end
        S_MOVF: state <= S_MOVS;
        S_MOVS: begin
          // shift entries down until the released slot is reached
          rinit[pos[PW-1:0]] <= 1'b1;
          carry <= rec_q;
          if (rec_q == sidx || pos == (PW+1)'(N - 1)) begin
            ovalid <= 1'b1;
            state <= S_IDLE;
          end else begin
            pos <= pos + (PW+1)'(1);
            state <= S_MOVF;
          end
        end
        S_FL: state <= S_FCHK;
        S_FCHK: state <= S_FOUT;
        S_FOUT: if (!ovalid) begin
          if (in_use[rec_q] && dirty[rec_q]) begin
            dirty[rec_q] <= 1'b0;
            res.result_slot <= rec_q;
            res.writeback_needed <= 1'b1;
            res.writeback_device <= tag_rd[7:0];
            res.writeback_block <= tag_rd[39:8];
            res.last <= dirty_left == '0;
            ovalid <= 1'b1;
          end
          if (dirty_left == '0 || pos == (PW+1)'(N - 1)) state <= S_IDLE;
          else begin
            pos <= pos + (PW+1)'(1);
            state <= S_FL;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast));
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready |-> !m_axis_tvalid);
  a_state_legal: assert property (@(posedge clk) disable iff (rst)
    state <= S_VTAG);
  a_reset: assert property (@(posedge clk)
    rst |=> state == S_IDLE && !m_axis_tvalid);
`endif
endmodule

### hdl/bbc_ram.sv
// Generic single-port-write, single-read synchronous RAM, registered read.
// No dependencies.
module bbc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

### verif/testbench.sv
// Self-checking bench for the buffer cache LRU manager: directed table, then
// random command sequences checked against a behavioural slot/recency predictor.
// Depends on bbc_pkg and block_buffer_cache_lru_manager.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [4:0]  slot;
    logic        hit;
    logic        fill;
    logic        wb;
    logic [7:0]  wb_dev;
    logic [31:0] wb_blk;
    logic [1:0]  status;
    logic        last;
  } cache_result_t;

  typedef struct {
    logic [2:0]    cmd;
    logic [7:0]    dev;
    logic [31:0]   blk;
    logic [4:0]    slot;
    bit            typed;
    cache_result_t res;
  } stim_row_t;

  localparam logic [2:0] CMD_SPARE6 = 3'd6;
  localparam logic [2:0] CMD_SPARE7 = 3'd7;
  localparam logic [31:0] BAD_BLOCK = 32'hFFFF_FFFF;
  localparam int DIR_ROWS = 24;
  localparam int NSLOT = bbc_pkg::SLOT_COUNT;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;
  logic        m_axis_tlast;

  block_buffer_cache_lru_manager dut (.*);

  // predictor state
  logic [7:0]  tag_dev [NSLOT];
  logic [31:0] tag_blk [NSLOT];
  bit          in_use  [NSLOT];
  bit          dirty   [NSLOT];
  logic [7:0]  refs    [NSLOT];
  logic [4:0]  lru     [NSLOT];

  cache_result_t pending_q[$];
  int  errors;
  bit  calm;
  bit  hold_req;

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic cache_result_t mk(logic [4:0] s, logic h, logic f, logic w,
                                       logic [7:0] d, logic [31:0] b,
                                       logic [1:0] st, logic l);
    cache_result_t r;
    r.slot = s; r.hit = h; r.fill = f; r.wb = w;
    r.wb_dev = d; r.wb_blk = b; r.status = st; r.last = l;
    return r;
  endfunction

  function automatic cache_result_t mk_plain(logic [4:0] s, logic [1:0] st);
    return mk(s, 1'b0, 1'b0, 1'b0, 8'd0, 32'd0, st, 1'b1);
  endfunction

  task automatic cache_reset();
    for (int i = 0; i < NSLOT; i++) begin
      in_use[i] = 0; dirty[i] = 0; refs[i] = '0;
      lru[i] = 5'(NSLOT - 1 - i);
    end
  endtask

  task automatic touch_front(logic [4:0] s);
    int p;
    p = 0;
    while (lru[p] != s) p++;
    for (; p > 0; p--) lru[p] = lru[p-1];
    lru[0] = s;
  endtask

  task automatic predict_cache(logic [2:0] cmd, logic [7:0] dev, logic [31:0] blk,
                               logic [4:0] slot);
    int n;
    logic [4:0] s;
    logic [1:0] st;
    bit done;
    done = 0;
    st = bbc_pkg::ST_OK;
    case (cmd)
      bbc_pkg::CMD_ACQUIRE: begin
        if (blk == BAD_BLOCK) begin
          pending_q.push_back(mk_plain(5'd0, bbc_pkg::ST_BAD));
          done = 1;
        end
        for (int p = 0; p < NSLOT && !done; p++) begin
          s = lru[p];
          if (in_use[s] && tag_dev[s] == dev && tag_blk[s] == blk) begin
            if (refs[s] != 8'hFF) refs[s]++;
            pending_q.push_back(mk(s, 1'b1, 1'b0, 1'b0, 8'd0, 32'd0, bbc_pkg::ST_OK, 1'b1));
            done = 1;
          end
        end
        for (int p = NSLOT - 1; p >= 0 && !done; p--) begin
          s = lru[p];
          if (refs[s] == 8'd0) begin
            if (in_use[s] && dirty[s])
              pending_q.push_back(mk(s, 1'b0, 1'b1, 1'b1, tag_dev[s], tag_blk[s],
                                     bbc_pkg::ST_OK, 1'b1));
            else
              pending_q.push_back(mk(s, 1'b0, 1'b1, 1'b0, 8'd0, 32'd0,
                                     bbc_pkg::ST_OK, 1'b1));
            tag_dev[s] = dev; tag_blk[s] = blk; in_use[s] = 1;
            dirty[s] = 0; refs[s] = 8'd1;
            done = 1;
          end
        end
        if (!done) pending_q.push_back(mk_plain(5'd0, bbc_pkg::ST_FULL));
      end
      bbc_pkg::CMD_FLUSH: begin
        n = 0;
        for (int p = 0; p < NSLOT && n < bbc_pkg::MAX_OUT; p++) begin
          s = lru[p];
          if (in_use[s] && dirty[s]) begin
            pending_q.push_back(mk(s, 1'b0, 1'b0, 1'b1, tag_dev[s], tag_blk[s],
                                   bbc_pkg::ST_OK, 1'b0));
            dirty[s] = 0;
            n++;
          end
        end
        if (n == 0) pending_q.push_back(mk_plain(5'd0, bbc_pkg::ST_OK));
        else pending_q[$].last = 1'b1;
      end
      bbc_pkg::CMD_RELEASE, bbc_pkg::CMD_UNPIN: begin
        if (refs[slot] == 8'd0) st = bbc_pkg::ST_UNDER;
        else begin
          refs[slot]--;
          if (cmd == bbc_pkg::CMD_RELEASE && refs[slot] == 8'd0) touch_front(slot);
        end
        pending_q.push_back(mk_plain(slot, st));
      end
      bbc_pkg::CMD_PIN: begin
        if (refs[slot] != 8'hFF) refs[slot]++;
        pending_q.push_back(mk_plain(slot, bbc_pkg::ST_OK));
      end
      bbc_pkg::CMD_DIRTY: begin
        if (in_use[slot]) dirty[slot] = 1;
        pending_q.push_back(mk_plain(slot, bbc_pkg::ST_OK));
      end
      default: pending_q.push_back(mk_plain(5'd0, bbc_pkg::ST_OK));
    endcase
  endtask

  function automatic int draw_gap();
    return calm ? 0 : $urandom_range(0, 17);
  endfunction

  task automatic send_item(stim_row_t r);
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {r.slot, r.blk, r.dev, r.cmd};
    do @(posedge clk); while (!s_axis_tready);
    predict_cache(r.cmd, r.dev, r.blk, r.slot);
    if (r.typed) begin
      void'(pending_q.pop_back());
      pending_q.push_back(r.res);
    end
    gap = draw_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_cmd(logic [2:0] c, logic [7:0] d, logic [31:0] b, logic [4:0] s);
    stim_row_t r;
    r.cmd = c; r.dev = d; r.blk = b; r.slot = s; r.typed = 0;
    send_item(r);
  endtask

  task automatic field_check(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  // result side
  initial begin
    int n;
    cache_result_t e;
    @(negedge rst);
    forever begin
      n = hold_req ? 400 : draw_gap();
      hold_req = 0;
      if (n > 0) begin
        m_axis_tready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected item, expected none, got %0h last %0b",
                 $time, m_axis_tdata, m_axis_tlast);
        errors++;
      end else begin
        e = pending_q.pop_front();
        field_check("result_slot", 32'(e.slot), 32'(m_axis_tdata[4:0]));
        field_check("was_hit", 32'(e.hit), 32'(m_axis_tdata[5]));
        field_check("fill_needed", 32'(e.fill), 32'(m_axis_tdata[6]));
        field_check("writeback_needed", 32'(e.wb), 32'(m_axis_tdata[7]));
        field_check("writeback_device", 32'(e.wb_dev), 32'(m_axis_tdata[15:8]));
        field_check("writeback_block", e.wb_blk, m_axis_tdata[47:16]);
        field_check("status", 32'(e.status), 32'(m_axis_tdata[49:48]));
        field_check("last", 32'(e.last), 32'(m_axis_tlast));
      end
    end
  end

  stim_row_t dir_table [DIR_ROWS] = '{
    '{bbc_pkg::CMD_RELEASE, 8'h00, 32'h0, 5'd3, 1'b1,
      '{5'd3, 1'b0, 1'b0, 1'b0, 8'h0, 32'h0, bbc_pkg::ST_UNDER, 1'b1}},
    '{bbc_pkg::CMD_UNPIN, 8'h00, 32'h0, 5'd31, 1'b1,
      '{5'd31, 1'b0, 1'b0, 1'b0, 8'h0, 32'h0, bbc_pkg::ST_UNDER, 1'b1}},
    '{bbc_pkg::CMD_ACQUIRE, 8'h00, BAD_BLOCK, 5'd0, 1'b1,
      '{5'd0, 1'b0, 1'b0, 1'b0, 8'h0, 32'h0, bbc_pkg::ST_BAD, 1'b1}},
    '{CMD_SPARE6, 8'hFF, 32'hFFFF_FFFF, 5'd31, 1'b1,
      '{5'd0, 1'b0, 1'b0, 1'b0, 8'h0, 32'h0, bbc_pkg::ST_OK, 1'b1}},
    '{CMD_SPARE7, 8'h55, 32'h1234, 5'd7, 1'b1,
      '{5'd0, 1'b0, 1'b0, 1'b0, 8'h0, 32'h0, bbc_pkg::ST_OK, 1'b1}},
    '{bbc_pkg::CMD_FLUSH, 8'h00, 32'h0, 5'd0, 1'b1,
      '{5'd0, 1'b0, 1'b0, 1'b0, 8'h0, 32'h0, bbc_pkg::ST_OK, 1'b1}},
    '{bbc_pkg::CMD_ACQUIRE, 8'h00, 32'h0, 5'd0, 1'b1,
      '{5'd0, 1'b0, 1'b1, 1'b0, 8'h0, 32'h0, bbc_pkg::ST_OK, 1'b1}},
    '{bbc_pkg::CMD_ACQUIRE, 8'hFF, 32'hFFFF_FFFE, 5'd0, 1'b0, '{default: '0}},
    '{bbc_pkg::CMD_ACQUIRE, 8'h00, 32'h0, 5'd0, 1'b0, '{default: '0}},
    '{bbc_pkg::CMD_DIRTY, 8'h00, 32'h0, 5'd0, 1'b0, '{default: '0}},
    '{bbc_pkg::CMD_DIRTY, 8'h00, 32'h0, 5'd1, 1'b0, '{default: '0}},
    '{bbc_pkg::CMD_DIRTY, 8'h00, 32'h0, 5'd9, 1'b0, '{default: '0}},
    '{bbc_pkg::CMD_PIN, 8'h00, 32'h0, 5'd1, 1'b0, '{default: '0}},
    '{bbc_pkg::CMD_UNPIN, 8'h00, 32'h0, 5'd1, 1'b0, '{default: '0}},
    '{bbc_pkg::CMD_RELEASE, 8'h00, 32'h0, 5'd0, 1'b0, '{default: '0}},
    '{bbc_pkg::CMD_RELEASE, 8'h00, 32'h0, 5'd0, 1'b0, '{default: '0}},
    '{bbc_pkg::CMD_FLUSH, 8'h00, 32'h0, 5'd0, 1'b0, '{default: '0}},
    '{bbc_pkg::CMD_DIRTY, 8'h00, 32'h0, 5'd0, 1'b0, '{default: '0}},
    '{bbc_pkg::CMD_ACQUIRE, 8'h80, 32'h8000_0000, 5'd0, 1'b0, '{default: '0}},
    '{bbc_pkg::CMD_RELEASE, 8'h00, 32'h0, 5'd1, 1'b0, '{default: '0}},
    '{bbc_pkg::CMD_RELEASE, 8'h00, 32'h0, 5'd0, 1'b0, '{default: '0}},
    '{bbc_pkg::CMD_ACQUIRE, 8'h01, 32'h1, 5'd0, 1'b0, '{default: '0}},
    '{bbc_pkg::CMD_PIN, 8'h00, 32'h0, 5'd31, 1'b0, '{default: '0}},
    '{bbc_pkg::CMD_RELEASE, 8'h00, 32'h0, 5'd31, 1'b0, '{default: '0}}
  };

  // stimulus
  initial begin
    int k, pick;
    bit paused;
    logic [2:0]  c;
    logic [7:0]  d;
    logic [31:0] b;
    errors = 0;
    calm = 0;
    hold_req = 0;
    paused = 0;
    cache_reset();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    foreach (dir_table[i]) send_item(dir_table[i]);

    hold_req = 1;
    k = 0;
    while (k < 96) begin
      if ($urandom_range(0, 29) == 0) calm = ~calm;
      if (k >= 48 && !paused) begin
        paused = 1;
        s_axis_tvalid <= 1'b0;
        wait (pending_q.size() == 0);
        @(posedge clk);
      end
      pick = $urandom_range(0, 99);
      if (pick < 2) begin
        for (int s = 0; s < NSLOT; s++) send_cmd(bbc_pkg::CMD_PIN, 8'd0, 32'd0, 5'(s));
        send_cmd(bbc_pkg::CMD_ACQUIRE, 8'($urandom),
                 $urandom_range(32'h100, 32'hFFFF_FFFE), 5'd0);
        for (int s = 0; s < NSLOT; s++) send_cmd(bbc_pkg::CMD_UNPIN, 8'd0, 32'd0, 5'(s));
        k += 2 * NSLOT + 1;
      end else begin
        pick = $urandom_range(0, 99);
        if      (pick < 40) c = bbc_pkg::CMD_ACQUIRE;
        else if (pick < 56) c = bbc_pkg::CMD_RELEASE;
        else if (pick < 64) c = bbc_pkg::CMD_PIN;
        else if (pick < 74) c = bbc_pkg::CMD_UNPIN;
        else if (pick < 89) c = bbc_pkg::CMD_DIRTY;
        else if (pick < 96) c = bbc_pkg::CMD_FLUSH;
        else c = ($urandom_range(0, 1) != 0) ? CMD_SPARE6 : CMD_SPARE7;
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
          d = 8'($urandom_range(0, 3) * 85);
          b = $urandom_range(0, 11);
        end else if (pick < 95) begin
          d = 8'($urandom);
          b = $urandom;
        end else begin
          d = 8'($urandom);
          b = BAD_BLOCK;
        end
        send_cmd(c, d, b, 5'($urandom_range(0, NSLOT - 1)));
        k++;
      end
    end
    // count saturation
    for (int i = 0; i < 258; i++) send_cmd(bbc_pkg::CMD_PIN, 8'd0, 32'd0, 5'd17);
    send_cmd(bbc_pkg::CMD_UNPIN, 8'd0, 32'd0, 5'd17);
    send_cmd(bbc_pkg::CMD_FLUSH, 8'd0, 32'd0, 5'd0);

    s_axis_tvalid <= 1'b0;
    wait (pending_q.size() == 0);
    repeat (100) @(posedge clk);
    if (errors == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end
endmodule
